/* rtl/dws_pkg.sv */
package dws_pkg;

  localparam int SAMPLE_W     = 8;
  localparam int TIME_W       = 15;
  localparam int TICK_W       = 8;
  localparam int SEG_LIST_W   = 18;
  localparam int SEG_CODE_W   = 3;
  localparam int SEG_CODES    = 6;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 15;
  // Wide enough for the largest sample store the parameters allow.
  localparam int STORE_ADDR_W = 10;

  localparam logic [TICK_W-1:0] HOLD_TICKS_RESET = 8'd18;
  localparam logic [TICK_W-1:0] UNIT_TICKS_RESET = 8'd20;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FLAT_TIME_ONE   = 3'd0,
    CFG_FLAT_AMP_ONE    = 3'd1,
    CFG_FLAT_TIME_TWO   = 3'd2,
    CFG_FLAT_AMP_TWO    = 3'd3,
    CFG_FLAT_TIME_THREE = 3'd4,
    CFG_FLAT_AMP_THREE  = 3'd5,
    CFG_HOLD_TICKS      = 3'd6,
    CFG_UNIT_TICKS      = 3'd7
  } cfg_reg_e;

  // Segment codes of a sequence.
  localparam logic [SEG_CODE_W-1:0] SEG_SKIP       = 3'd0;
  localparam logic [SEG_CODE_W-1:0] SEG_WAVE_ONE   = 3'd1;
  localparam logic [SEG_CODE_W-1:0] SEG_WAVE_TWO   = 3'd2;
  localparam logic [SEG_CODE_W-1:0] SEG_WAVE_THREE = 3'd3;
  localparam logic [SEG_CODE_W-1:0] SEG_FLAT_ONE   = 3'd4;
  localparam logic [SEG_CODE_W-1:0] SEG_FLAT_TWO   = 3'd5;
  localparam logic [SEG_CODE_W-1:0] SEG_FLAT_THREE = 3'd6;
  localparam logic [SEG_CODE_W-1:0] SEG_SHORT      = 3'd7;

  localparam logic [1:0] TSEL_SHORT = 2'd3;

  // Where the DAC code of a transaction comes from once it reaches the output stage.
  typedef enum logic [1:0] {
    DAC_KEEP  = 2'd0,
    DAC_CONST = 2'd1,
    DAC_MEM   = 2'd2
  } dac_sel_e;

  typedef struct packed {
    logic [TIME_W-1:0]   flat_time_one;
    logic [SAMPLE_W-1:0] flat_amp_one;
    logic [TIME_W-1:0]   flat_time_two;
    logic [SAMPLE_W-1:0] flat_amp_two;
    logic [TIME_W-1:0]   flat_time_three;
    logic [SAMPLE_W-1:0] flat_amp_three;
    logic [TICK_W-1:0]   hold_ticks;
    logic [TICK_W-1:0]   unit_ticks;
  } cfg_t;

  typedef struct packed {
    dac_sel_e            dac_sel;
    logic [SAMPLE_W-1:0] dac_const;
    logic                busy;
    logic                done;
    logic                refused;
  } res_t;

  typedef struct packed {
    logic                    wr_en;
    logic [STORE_ADDR_W-1:0] wr_addr;
    logic [SAMPLE_W-1:0]     wr_data;
    logic                    rd_en;
    logic [STORE_ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

/* rtl/dac_waveform_sequencer.sv */
// DAC waveform sequencer.
// Input channel (in_valid_i / in_stall_o) carries one transaction per item: a sample
// load, a sequence start or a playback tick, chosen by opcode_i. Output channel
// (out_valid_o / out_stall_i) returns exactly one result transaction per input
// transaction, in order: the DAC code after the item, the busy flag, the
// end-of-sequence pulse and the refused flag for loads and starts met while busy.
// The configuration channel (cfg_valid_i / cfg_ready_o) is always ready and should
// be written only while the block is idle.
// A valid result appears in the cycle after input acceptance, and throughput is
// one transaction per cycle when not stalled, so a tick can be taken on every clock.
// The rate is set by the sample store: each item issues at most one read of the
// store, whose registered read data is merged into the result in the output register.
// Reset clears the sequencer state, sets the configuration registers to their
// defaults and marks every sample entry unwritten, so it reads as zero at once;
// no clearing pass is needed. When the receiver stalls, the result is held in the
// output register and the input is stalled in the same cycle; no transaction is lost.
module dac_waveform_sequencer #(
  parameter int TABLE_DEPTH     = 20,
  parameter int SHORT_DEPTH     = 10,
  parameter int SEQUENCE_LENGTH = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        opcode_i,
  input  logic [1:0]                        table_select_i,
  input  logic [4:0]                        sample_index_i,
  input  logic [dws_pkg::SAMPLE_W-1:0]      sample_value_i,
  input  logic [dws_pkg::SEG_LIST_W-1:0]    segment_list_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [dws_pkg::SAMPLE_W-1:0]      dac_value_o,
  output logic                              busy_res_o,
  output logic                              sequence_done_o,
  output logic                              refused_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dws_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [dws_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // Three waveform tables followed by the short table, all in one store.
  localparam int STORE_DEPTH = 3 * TABLE_DEPTH + SHORT_DEPTH;

  dws_pkg::cfg_t     cfg_q;
  dws_pkg::res_t     res;
  dws_pkg::res_t     out_q;
  dws_pkg::mem_req_t req;
  logic              out_valid_q;
  logic [dws_pkg::SAMPLE_W-1:0] dac_q;
  logic [dws_pkg::SAMPLE_W-1:0] rd_data;
  logic              in_accept;
  logic              out_accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_accept  = out_valid_q && !out_stall_i;

  // Configuration registers; each write takes only the bits its register holds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{flat_time_one: '0, flat_amp_one: '0, flat_time_two: '0, flat_amp_two: '0,
                 flat_time_three: '0, flat_amp_three: '0,
                 hold_ticks: dws_pkg::HOLD_TICKS_RESET,
                 unit_ticks: dws_pkg::UNIT_TICKS_RESET};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (dws_pkg::cfg_reg_e'(cfg_index_i))
        dws_pkg::CFG_FLAT_TIME_ONE:   cfg_q.flat_time_one   <= cfg_data_i;
        dws_pkg::CFG_FLAT_AMP_ONE:    cfg_q.flat_amp_one    <= cfg_data_i[7:0];
        dws_pkg::CFG_FLAT_TIME_TWO:   cfg_q.flat_time_two   <= cfg_data_i;
        dws_pkg::CFG_FLAT_AMP_TWO:    cfg_q.flat_amp_two    <= cfg_data_i[7:0];
        dws_pkg::CFG_FLAT_TIME_THREE: cfg_q.flat_time_three <= cfg_data_i;
        dws_pkg::CFG_FLAT_AMP_THREE:  cfg_q.flat_amp_three  <= cfg_data_i[7:0];
        dws_pkg::CFG_HOLD_TICKS:      cfg_q.hold_ticks      <= cfg_data_i[7:0];
        dws_pkg::CFG_UNIT_TICKS:      cfg_q.unit_ticks      <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // The sequencer decides the next state in the cycle the item is accepted and
  // issues at most one store access.
  dws_ctrl #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .SHORT_DEPTH     (SHORT_DEPTH),
    .SEQUENCE_LENGTH (SEQUENCE_LENGTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .opcode_i       (dws_pkg::opcode_e'(opcode_i)),
    .table_select_i (table_select_i),
    .sample_index_i (sample_index_i),
    .sample_value_i (sample_value_i),
    .segment_list_i (segment_list_i),
    .cfg_i          (cfg_q),
    .res_o          (res),
    .req_o          (req)
  );

  dws_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  // Output register. The store's read data arrives in the same cycle the result
  // does, and is held by the store for as long as the result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_accept) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= res;
    end
  end

  // The DAC level is the code of the last delivered result; an item that leaves
  // the level alone shows it again.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dac_q <= '0;
    end else if (out_accept) begin
      dac_q <= dac_value_o;
    end
  end

  always_comb begin
    unique case (out_q.dac_sel)
      dws_pkg::DAC_CONST: dac_value_o = out_q.dac_const;
      dws_pkg::DAC_MEM:   dac_value_o = rd_data;
      default:            dac_value_o = dac_q;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign busy_res_o      = out_q.busy;
  assign sequence_done_o = out_q.done;
  assign refused_o       = out_q.refused;

endmodule

/* rtl/dws_store.sv */
module dws_store #(
  parameter int DEPTH = 70
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dws_pkg::mem_req_t             req_i,
  output logic [dws_pkg::SAMPLE_W-1:0]  rd_data_o
);

  localparam int AW = $clog2(DEPTH);

  logic [dws_pkg::SAMPLE_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]             valid_q;
  logic [dws_pkg::SAMPLE_W-1:0] rd_q;
  logic                         rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr[AW-1:0]];
    end
  end

  // An entry that has never been written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

/* rtl/dws_ctrl.sv */
module dws_ctrl #(
  parameter int TABLE_DEPTH     = 20,
  parameter int SHORT_DEPTH     = 10,
  parameter int SEQUENCE_LENGTH = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  dws_pkg::opcode_e                opcode_i,
  input  logic [1:0]                      table_select_i,
  input  logic [4:0]                      sample_index_i,
  input  logic [dws_pkg::SAMPLE_W-1:0]    sample_value_i,
  input  logic [dws_pkg::SEG_LIST_W-1:0]  segment_list_i,
  input  dws_pkg::cfg_t                   cfg_i,
  output dws_pkg::res_t                   res_o,
  output dws_pkg::mem_req_t               req_o
);

  localparam int LISTW = dws_pkg::SEG_CODE_W * SEQUENCE_LENGTH;
  localparam int PADW  = (LISTW > dws_pkg::SEG_LIST_W) ? LISTW : dws_pkg::SEG_LIST_W;
  localparam int FW    = $clog2(SEQUENCE_LENGTH + 1);
  localparam int MAXD  = (TABLE_DEPTH > SHORT_DEPTH) ? TABLE_DEPTH : SHORT_DEPTH;
  localparam int SAW   = $clog2(MAXD + 1);
  localparam int AW    = dws_pkg::STORE_ADDR_W;
  localparam int CW    = dws_pkg::SEG_CODE_W;

  function automatic logic is_table(input logic [CW-1:0] code);
    logic r;
    unique case (code) inside
      dws_pkg::SEG_WAVE_ONE, dws_pkg::SEG_WAVE_TWO, dws_pkg::SEG_WAVE_THREE,
      dws_pkg::SEG_SHORT: r = 1'b1;
      default:            r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_flat(input logic [CW-1:0] code);
    logic r;
    unique case (code) inside
      dws_pkg::SEG_FLAT_ONE, dws_pkg::SEG_FLAT_TWO, dws_pkg::SEG_FLAT_THREE: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [AW-1:0] base_of(input logic [CW-1:0] code);
    logic [AW-1:0] r;
    unique case (code)
      dws_pkg::SEG_WAVE_TWO:   r = AW'(TABLE_DEPTH);
      dws_pkg::SEG_WAVE_THREE: r = AW'(2 * TABLE_DEPTH);
      dws_pkg::SEG_SHORT:      r = AW'(3 * TABLE_DEPTH);
      default:                 r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [SAW-1:0] depth_of(input logic [CW-1:0] code);
    return (code == dws_pkg::SEG_SHORT) ? SAW'(SHORT_DEPTH) : SAW'(TABLE_DEPTH);
  endfunction

  function automatic logic [dws_pkg::TIME_W-1:0] time_of(input dws_pkg::cfg_t cfg,
                                                        input logic [CW-1:0] code);
    logic [dws_pkg::TIME_W-1:0] r;
    unique case (code)
      dws_pkg::SEG_FLAT_ONE: r = cfg.flat_time_one;
      dws_pkg::SEG_FLAT_TWO: r = cfg.flat_time_two;
      default:               r = cfg.flat_time_three;
    endcase
    return r;
  endfunction

  function automatic logic [dws_pkg::SAMPLE_W-1:0] amp_of(input dws_pkg::cfg_t cfg,
                                                         input logic [CW-1:0] code);
    logic [dws_pkg::SAMPLE_W-1:0] r;
    unique case (code)
      dws_pkg::SEG_FLAT_ONE: r = cfg.flat_amp_one;
      dws_pkg::SEG_FLAT_TWO: r = cfg.flat_amp_two;
      default:               r = cfg.flat_amp_three;
    endcase
    return r;
  endfunction

  logic [dws_pkg::SEG_LIST_W-1:0] active_q, active_d;
  logic [FW-1:0]                  seg_pos_q, seg_pos_d;
  logic [SAW-1:0]                 samp_q, samp_d;
  logic [dws_pkg::TICK_W-1:0]     tick_q, tick_d;
  logic [dws_pkg::TIME_W-1:0]     units_q, units_d;
  logic                           playing_q, playing_d;

  logic [PADW-1:0] src_pad;
  logic [PADW-1:0] act_pad;
  logic [FW-1:0]   ent_from;
  logic            ent_found;
  logic [FW-1:0]   ent_pos;
  logic [CW-1:0]   ent_code;
  logic            ent_zero;
  logic [CW-1:0]   cur_code;

  logic                       is_start;
  logic [dws_pkg::TICK_W-1:0] tick_inc;
  logic [SAW-1:0]             samp_inc;
  logic [dws_pkg::TIME_W-1:0] units_dec;

  assign is_start = (opcode_i == dws_pkg::OP_START);
  assign src_pad  = is_start ? PADW'(segment_list_i) : PADW'(active_q);
  assign act_pad  = PADW'(active_q);
  assign ent_from = is_start ? '0 : seg_pos_q + FW'(1);
  assign tick_inc = tick_q + dws_pkg::TICK_W'(1);
  assign samp_inc = samp_q + SAW'(1);
  assign units_dec = units_q - dws_pkg::TIME_W'(1);

  // Code of the segment now playing.
  always_comb begin
    cur_code = dws_pkg::SEG_SKIP;
    for (int p = 0; p < SEQUENCE_LENGTH; p++) begin
      if (seg_pos_q == FW'(p)) begin
        cur_code = act_pad[CW*p +: CW];
      end
    end
  end

  // First playable segment at or after ent_from. Flat pulses of zero length are
  // passed over but leave the DAC at zero.
  always_comb begin
    logic [CW-1:0] c;
    ent_found = 1'b0;
    ent_pos   = '0;
    ent_code  = dws_pkg::SEG_SKIP;
    ent_zero  = 1'b0;
    for (int p = 0; p < SEQUENCE_LENGTH; p++) begin
      c = src_pad[CW*p +: CW];
      if (!ent_found && (FW'(p) >= ent_from)) begin
        if (is_table(c) || (is_flat(c) && (time_of(cfg_i, c) != '0))) begin
          ent_found = 1'b1;
          ent_pos   = FW'(p);
          ent_code  = c;
        end else if (is_flat(c)) begin
          ent_zero = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic use_enter;
    logic force_zero;
    active_d   = active_q;
    seg_pos_d  = seg_pos_q;
    samp_d     = samp_q;
    tick_d     = tick_q;
    units_d    = units_q;
    playing_d  = playing_q;
    use_enter  = 1'b0;
    force_zero = 1'b0;
    res_o      = '{dac_sel: dws_pkg::DAC_KEEP, dac_const: '0, busy: 1'b0,
                   done: 1'b0, refused: 1'b0};
    req_o      = '0;

    unique case (opcode_i)
      dws_pkg::OP_LOAD: begin
        if (playing_q) begin
          res_o.refused = 1'b1;
        end else if (table_select_i != dws_pkg::TSEL_SHORT) begin
          if (int'(sample_index_i) < TABLE_DEPTH) begin
            req_o.wr_en   = accept_i;
            req_o.wr_addr = base_of(CW'(table_select_i) + CW'(1)) + AW'(sample_index_i);
          end
        end else if (int'(sample_index_i) < SHORT_DEPTH) begin
          req_o.wr_en   = accept_i;
          req_o.wr_addr = base_of(dws_pkg::SEG_SHORT) + AW'(sample_index_i);
        end
        req_o.wr_data = sample_value_i;
      end
      dws_pkg::OP_START: begin
        if (playing_q) begin
          res_o.refused = 1'b1;
        end else begin
          active_d  = segment_list_i;
          seg_pos_d = '0;
          use_enter = 1'b1;
        end
      end
      dws_pkg::OP_TICK: begin
        if (playing_q) begin
          if (is_flat(cur_code)) begin
            if (tick_inc >= cfg_i.unit_ticks) begin
              tick_d  = '0;
              units_d = units_dec;
              if (units_dec == '0) begin
                force_zero = 1'b1;
                use_enter  = 1'b1;
              end
            end else begin
              tick_d = tick_inc;
            end
          end else if (tick_inc >= cfg_i.hold_ticks) begin
            tick_d = '0;
            samp_d = samp_inc;
            if (samp_inc >= depth_of(cur_code)) begin
              use_enter = 1'b1;
            end else begin
              res_o.dac_sel = dws_pkg::DAC_MEM;
              req_o.rd_en   = accept_i;
              req_o.rd_addr = base_of(cur_code) + AW'(samp_inc);
            end
          end else begin
            tick_d = tick_inc;
          end
        end
      end
      default: begin
      end
    endcase

    if (use_enter) begin
      if (ent_found) begin
        seg_pos_d = ent_pos;
        tick_d    = '0;
        playing_d = 1'b1;
        if (is_table(ent_code)) begin
          samp_d        = '0;
          res_o.dac_sel = dws_pkg::DAC_MEM;
          req_o.rd_en   = accept_i;
          req_o.rd_addr = base_of(ent_code);
        end else begin
          units_d         = time_of(cfg_i, ent_code);
          res_o.dac_sel   = dws_pkg::DAC_CONST;
          res_o.dac_const = amp_of(cfg_i, ent_code);
        end
      end else begin
        playing_d  = 1'b0;
        res_o.done = 1'b1;
        if (ent_zero || force_zero) begin
          res_o.dac_sel = dws_pkg::DAC_CONST;
        end
      end
    end

    res_o.busy = playing_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      seg_pos_q <= '0;
      samp_q    <= '0;
      tick_q    <= '0;
      units_q   <= '0;
      playing_q <= 1'b0;
    end else if (accept_i) begin
      active_q  <= active_d;
      seg_pos_q <= seg_pos_d;
      samp_q    <= samp_d;
      tick_q    <= tick_d;
      units_q   <= units_d;
      playing_q <= playing_d;
    end
  end

endmodule

/* rtl/dws_checker.sv */
module dws_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [dws_pkg::SAMPLE_W-1:0]     dac_value_o,
  input logic                             busy_res_o,
  input logic                             sequence_done_o,
  input logic                             refused_o
);

  // Every accepted input transaction produces a result on the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

  // A finished sequence is no longer busy.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sequence_done_o |-> !busy_res_o)
    else $error("sequence end reported while still busy");

  // Only a busy block refuses, and refusing leaves it busy.
  a_refused_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && refused_o |-> busy_res_o && !sequence_done_o)
    else $error("refusal reported on an idle block");

  a_stall_keeps_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_stall_keeps_dac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(dac_value_o))
    else $error("DAC code changed while stalled");

endmodule

bind dac_waveform_sequencer dws_checker u_dws_checker (.*);

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import dws_pkg::*;

  // Sizes of the instance under test; the defaults of the block.
  localparam int TABLE_DEPTH     = 20;
  localparam int SHORT_DEPTH     = 10;
  localparam int SEQUENCE_LENGTH = 6;
  localparam int STORE_DEPTH     = 3 * TABLE_DEPTH + SHORT_DEPTH;

  // Each side waits up to this many cycles per transaction when idling is on.
  localparam int MAX_WAIT        = 18;
  // The long stretch during which the receiver refuses every result.
  localparam int HOLD_OFF_CYCLES = 400;
  // The slowest correct run never goes longer without a transaction than the
  // hold-off plus one stall; the limit is several times that.
  localparam int WATCHDOG_LIMIT  = 2000;
  // The result arrives in the cycle after its input is taken, so this much settling is ample.
  localparam int SETTLE_CYCLES   = 4;

  typedef struct {
    opcode_e                 op;
    logic [1:0]              tsel;
    logic [4:0]              idx;
    logic [SAMPLE_W-1:0]     val;
    logic [SEG_LIST_W-1:0]   segs;
  } dws_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] dac;
    logic                busy;
    logic                done;
    logic                refused;
  } dac_result_t;

  // Clock, reset and every input of the block start at a known value.
  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic [1:0]             opcode       = OP_NOP;
  logic [1:0]             table_select = '0;
  logic [4:0]             sample_index = '0;
  logic [SAMPLE_W-1:0]    sample_value = '0;
  logic [SEG_LIST_W-1:0]  segment_list = '0;
  logic                   out_stall    = 1'b0;
  logic                   cfg_valid    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  logic                   in_stall;
  logic                   out_valid;
  logic [SAMPLE_W-1:0]    dac_value;
  logic                   busy_res;
  logic                   sequence_done;
  logic                   refused;
  logic                   cfg_ready;

  dac_waveform_sequencer #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .SHORT_DEPTH     (SHORT_DEPTH),
    .SEQUENCE_LENGTH (SEQUENCE_LENGTH)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .table_select_i  (table_select),
    .sample_index_i  (sample_index),
    .sample_value_i  (sample_value),
    .segment_list_i  (segment_list),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .dac_value_o     (dac_value),
    .busy_res_o      (busy_res),
    .sequence_done_o (sequence_done),
    .refused_o       (refused),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state. This is a private copy of everything the sequencer keeps:
  // the sample store, the playback position and the configuration registers.
  // It is advanced once per accepted input transaction, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0]   sample_mem [STORE_DEPTH];
  logic [SAMPLE_W-1:0]   dac_level;
  logic [SEG_LIST_W-1:0] seg_list;
  int unsigned           seg_pos;
  int unsigned           smp_pos;
  logic [TICK_W-1:0]     tick_cnt;
  logic [TIME_W-1:0]     units_left;
  bit                    playing;
  logic [TIME_W-1:0]     flat_time [3];
  logic [SAMPLE_W-1:0]   flat_amp [3];
  logic [TICK_W-1:0]     hold_ticks;
  logic [TICK_W-1:0]     unit_ticks;

  // Transactions waiting to be offered, and the results predicted for the
  // transactions already accepted, oldest first.
  dws_item_t   pending_items[$];
  dac_result_t predicted_results[$];
  dws_item_t   cur_item;

  int unsigned pushed_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count  = 0;
  int unsigned errors         = 0;
  int unsigned done_seen      = 0;
  int unsigned refused_seen   = 0;
  int unsigned settings_count = 1;
  int unsigned idle_cycles    = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  bit          sender_idle_on = 1'b1;
  bit          receiver_idle_on = 1'b1;
  logic        hold_req       = 1'b0;

  function automatic logic [SEG_CODE_W-1:0] code_at(int unsigned pos);
    if (pos >= SEQUENCE_LENGTH) return SEG_SKIP;
    return seg_list[SEG_CODE_W*pos +: SEG_CODE_W];
  endfunction

  function automatic bit is_table_code(logic [SEG_CODE_W-1:0] code);
    return (code >= SEG_WAVE_ONE && code <= SEG_WAVE_THREE) || code == SEG_SHORT;
  endfunction

  function automatic bit is_flat_code(logic [SEG_CODE_W-1:0] code);
    return code >= SEG_FLAT_ONE && code <= SEG_FLAT_THREE;
  endfunction

  function automatic int unsigned table_base(logic [SEG_CODE_W-1:0] code);
    return code == SEG_SHORT ? 3 * TABLE_DEPTH : int'(code - SEG_WAVE_ONE) * TABLE_DEPTH;
  endfunction

  function automatic int unsigned table_len(logic [SEG_CODE_W-1:0] code);
    return code == SEG_SHORT ? SHORT_DEPTH : TABLE_DEPTH;
  endfunction

  // Moves to the first segment at or after pos that has something to play.
  // Flat pulses of zero length are passed over but still drop the DAC to zero.
  // Returns 1 when the list is exhausted, which ends the sequence.
  function automatic bit enter_segment(int unsigned pos);
    logic [SEG_CODE_W-1:0] code;
    int unsigned           f;
    while (pos < SEQUENCE_LENGTH) begin
      code = code_at(pos);
      if (is_table_code(code)) begin
        seg_pos   = pos;
        smp_pos   = 0;
        tick_cnt  = '0;
        dac_level = sample_mem[table_base(code)];
        playing   = 1'b1;
        return 1'b0;
      end
      if (is_flat_code(code)) begin
        f = int'(code - SEG_FLAT_ONE);
        if (flat_time[f] == '0) begin
          dac_level = '0;
        end else begin
          seg_pos    = pos;
          units_left = flat_time[f];
          tick_cnt   = '0;
          dac_level  = flat_amp[f];
          playing    = 1'b1;
          return 1'b0;
        end
      end
      pos++;
    end
    playing = 1'b0;
    return 1'b1;
  endfunction

  // One playback tick. A hold or unit length of zero behaves as one, which
  // falls out of the greater-or-equal comparison.
  function automatic bit advance_tick();
    logic [SEG_CODE_W-1:0] code;
    code     = code_at(seg_pos);
    tick_cnt = tick_cnt + 1'b1;
    if (is_flat_code(code)) begin
      if (tick_cnt >= unit_ticks) begin
        tick_cnt   = '0;
        units_left = units_left - 1'b1;
        if (units_left == '0) begin
          dac_level = '0;
          return enter_segment(seg_pos + 1);
        end
      end
      return 1'b0;
    end
    if (tick_cnt >= hold_ticks) begin
      tick_cnt = '0;
      smp_pos++;
      if (smp_pos >= table_len(code)) return enter_segment(seg_pos + 1);
      dac_level = sample_mem[table_base(code) + smp_pos];
    end
    return 1'b0;
  endfunction

  // Predicts the result of one input transaction and updates the state.
  function automatic dac_result_t sequencer_step(dws_item_t it);
    dac_result_t r;
    bit          done_now;
    bit          refused_now;
    done_now    = 1'b0;
    refused_now = 1'b0;
    case (it.op)
      OP_LOAD: begin
        if (playing) begin
          refused_now = 1'b1;
        end else if (it.tsel != TSEL_SHORT) begin
          if (it.idx < TABLE_DEPTH) sample_mem[int'(it.tsel) * TABLE_DEPTH + it.idx] = it.val;
        end else if (it.idx < SHORT_DEPTH) begin
          sample_mem[3 * TABLE_DEPTH + it.idx] = it.val;
        end
      end
      OP_START: begin
        if (playing) begin
          refused_now = 1'b1;
        end else begin
          seg_list = it.segs;
          seg_pos  = 0;
          done_now = enter_segment(0);
        end
      end
      OP_TICK: begin
        if (playing) done_now = advance_tick();
      end
      default: begin
      end
    endcase
    r.dac     = dac_level;
    r.busy    = playing;
    r.done    = done_now;
    r.refused = refused_now;
    return r;
  endfunction

  function automatic int unsigned draw_wait(bit idling);
    return idling ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. At each rising edge it notes whether the offered transaction was
  // taken, predicts its result, and then either offers the next item from the
  // queue or idles for the number of cycles drawn for that item. While the
  // receiver is holding off, the sender keeps offering without gaps so that
  // the block fills up and has to stall its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin : drive
      bit taken;
      taken = in_valid && !in_stall;
      if (taken) begin
        predicted_results.push_back(sequencer_step(cur_item));
        accepted_count++;
      end
      if (!in_valid || taken) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_item = pending_items.pop_front();
          opcode       <= cur_item.op;
          table_select <= cur_item.tsel;
          sample_index <= cur_item.idx;
          sample_value <= cur_item.val;
          segment_list <= cur_item.segs;
          in_valid     <= 1'b1;
          if ($urandom_range(0, 63) == 0) sender_idle_on = !sender_idle_on;
          gap_left = hold_req ? 0 : draw_wait(sender_idle_on);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every result transaction is checked field by field against the
  // oldest prediction. After each one the receiver draws how long it will
  // stall before taking the next.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin : check
      dac_result_t want;
      if (out_valid && !out_stall) begin
        if (sequence_done) done_seen++;
        if (refused) refused_seen++;
        if (predicted_results.size() == 0) begin
          $display("%0t: result with nothing predicted: dac %0d busy %0b done %0b refused %0b",
                   $time, dac_value, busy_res, sequence_done, refused);
          errors++;
        end else begin
          want = predicted_results.pop_front();
          checked_count++;
          if (dac_value !== want.dac) begin
            $display("%0t: dac_value expected %0d, got %0d", $time, want.dac, dac_value);
            errors++;
          end
          if (busy_res !== want.busy) begin
            $display("%0t: busy_res expected %0b, got %0b", $time, want.busy, busy_res);
            errors++;
          end
          if (sequence_done !== want.done) begin
            $display("%0t: sequence_done expected %0b, got %0b", $time, want.done,
                     sequence_done);
            errors++;
          end
          if (refused !== want.refused) begin
            $display("%0t: refused expected %0b, got %0b", $time, want.refused, refused);
            errors++;
          end
        end
        if ($urandom_range(0, 63) == 0) receiver_idle_on = !receiver_idle_on;
        stall_left = draw_wait(receiver_idle_on);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= hold_req || (stall_left > 0);
    end
  end

  // Once the run is well under way, the receiver refuses all results for a
  // long stretch. The cycles are counted here rather than in the monitor.
  initial begin : receiver_hold_off
    wait (accepted_count >= 900);
    @(posedge clk);
    hold_req <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_req <= 1'b0;
  end

  // The watchdog ends a run in which no transaction of any kind completes for
  // too long, which is how a lost result shows itself.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("dac_waveform_sequencer: mismatch");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic add_item(opcode_e op, logic [1:0] tsel, logic [4:0] idx,
                          logic [SAMPLE_W-1:0] val, logic [SEG_LIST_W-1:0] segs);
    dws_item_t it;
    it.op   = op;
    it.tsel = tsel;
    it.idx  = idx;
    it.val  = val;
    it.segs = segs;
    pending_items.push_back(it);
    pushed_count++;
  endtask

  task automatic add_noise_item();
    add_item(opcode_e'($urandom_range(0, 3)), 2'($urandom), 5'($urandom), 8'($urandom),
             18'($urandom));
  endtask

  // Mostly sparse lists with a few playable segments, so that sequences end
  // within a reasonable number of ticks; now and then a fully random list.
  function automatic logic [SEG_LIST_W-1:0] random_segments();
    logic [SEG_LIST_W-1:0] s;
    if ($urandom_range(0, 4) == 0) return 18'($urandom);
    s = '0;
    for (int i = 0; i < SEQUENCE_LENGTH; i++) begin
      if ($urandom_range(0, 9) < 6) s[SEG_CODE_W*i +: SEG_CODE_W] = 3'($urandom_range(1, 7));
    end
    return s;
  endfunction

  // Well-formed sequences with random content: a few loads, a start, then a
  // run of ticks with the odd refused or unused transaction mixed in. The
  // remainder is pure noise. The last run of ticks is cut short so that the
  // batch stays close to the requested size.
  task automatic add_random_items(int unsigned count, int unsigned tick_max);
    int unsigned target;
    int unsigned n;
    logic [1:0]  tsel;
    logic [4:0]  idx;
    target = pushed_count + count;
    while (pushed_count < target) begin
      if ($urandom_range(0, 99) < 85) begin
        n = $urandom_range(0, 6);
        repeat (n) begin
          tsel = 2'($urandom_range(0, 3));
          if ($urandom_range(0, 9) == 0) idx = 5'($urandom);
          else idx = 5'($urandom_range(0, tsel == TSEL_SHORT ? SHORT_DEPTH - 1
                                                             : TABLE_DEPTH - 1));
          add_item(OP_LOAD, tsel, idx, 8'($urandom), 18'($urandom));
        end
        add_item(OP_START, 2'($urandom), 5'($urandom), 8'($urandom), random_segments());
        n = $urandom_range(5, tick_max);
        if (pushed_count + n > target) n = (pushed_count < target) ? target - pushed_count : 0;
        repeat (n) begin
          if ($urandom_range(0, 39) == 0) add_noise_item();
          else add_item(OP_TICK, 2'($urandom), 5'($urandom), 8'($urandom), 18'($urandom));
        end
      end else begin
        add_noise_item();
      end
    end
  endtask

  // Waits until every transaction handed to the driver has had its result
  // checked, then lets the block settle.
  task automatic drain();
    while (checked_count != pushed_count) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register and mirrors the write into the predictor once the
  // transaction has been taken.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FLAT_TIME_ONE:   flat_time[0] = data;
      CFG_FLAT_AMP_ONE:    flat_amp[0]  = data[SAMPLE_W-1:0];
      CFG_FLAT_TIME_TWO:   flat_time[1] = data;
      CFG_FLAT_AMP_TWO:    flat_amp[1]  = data[SAMPLE_W-1:0];
      CFG_FLAT_TIME_THREE: flat_time[2] = data;
      CFG_FLAT_AMP_THREE:  flat_amp[2]  = data[SAMPLE_W-1:0];
      CFG_HOLD_TICKS:      hold_ticks   = data[TICK_W-1:0];
      CFG_UNIT_TICKS:      unit_ticks   = data[TICK_W-1:0];
      default: begin
      end
    endcase
  endtask

  // Writes the whole register set. The eight-bit registers get random upper
  // data bits, which the block must discard.
  task automatic configure(logic [TIME_W-1:0] t1, logic [7:0] a1, logic [TIME_W-1:0] t2,
                           logic [7:0] a2, logic [TIME_W-1:0] t3, logic [7:0] a3,
                           logic [7:0] hold, logic [7:0] unit);
    write_reg(CFG_FLAT_TIME_ONE,   t1);
    write_reg(CFG_FLAT_AMP_ONE,    {7'($urandom), a1});
    write_reg(CFG_FLAT_TIME_TWO,   t2);
    write_reg(CFG_FLAT_AMP_TWO,    {7'($urandom), a2});
    write_reg(CFG_FLAT_TIME_THREE, t3);
    write_reg(CFG_FLAT_AMP_THREE,  {7'($urandom), a3});
    write_reg(CFG_HOLD_TICKS,      {7'($urandom), hold});
    write_reg(CFG_UNIT_TICKS,      {7'($urandom), unit});
    settings_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    foreach (sample_mem[i]) sample_mem[i] = '0;
    foreach (flat_time[i]) begin
      flat_time[i] = '0;
      flat_amp[i]  = '0;
    end
    hold_ticks = HOLD_TICKS_RESET;
    unit_ticks = UNIT_TICKS_RESET;
    dac_level  = '0;
    seg_list   = '0;
    seg_pos    = 0;
    smp_pos    = 0;
    tick_cnt   = '0;
    units_left = '0;
    playing    = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the register values that reset leaves. An idle
    // tick and the unused opcode must change nothing.
    add_item(OP_TICK, 2'd0, 5'd0, 8'd0, '0);
    add_item(OP_NOP, 2'd3, 5'd31, 8'hFF, '1);
    // Loads at the ends of the tables, including indices past the end,
    // which are dropped without being refused.
    add_item(OP_LOAD, 2'd0, 5'd0, 8'hFF, '0);
    add_item(OP_LOAD, 2'd0, 5'd19, 8'hA5, '0);
    add_item(OP_LOAD, 2'd0, 5'd20, 8'h11, '0);
    add_item(OP_LOAD, 2'd1, 5'd0, 8'h5A, '0);
    add_item(OP_LOAD, 2'd2, 5'd19, 8'hFF, '0);
    add_item(OP_LOAD, 2'd2, 5'd31, 8'h22, '0);
    add_item(OP_LOAD, TSEL_SHORT, 5'd0, 8'h81, '0);
    add_item(OP_LOAD, TSEL_SHORT, 5'd9, 8'h7E, '0);
    add_item(OP_LOAD, TSEL_SHORT, 5'd10, 8'hEE, '0);
    // A list of nothing but skipped codes ends on the start itself, and so
    // does a list of flat pulses that all have zero length.
    add_item(OP_START, 2'd0, 5'd0, 8'd0, '0);
    add_item(OP_START, 2'd0, 5'd0, 8'd0,
             18'({SEG_FLAT_THREE, SEG_FLAT_TWO, SEG_FLAT_ONE}));
    // Start the short table, then show that loads and starts are refused
    // while it plays and that it stays busy through the ticks that follow.
    add_item(OP_START, 2'd0, 5'd0, 8'd0, 18'(SEG_SHORT));
    add_item(OP_LOAD, 2'd0, 5'd1, 8'h33, '0);
    add_item(OP_START, 2'd0, 5'd0, 8'd0, 18'(SEG_WAVE_ONE));
    add_item(OP_NOP, 2'd0, 5'd0, 8'd0, '0);
    repeat (4) add_item(OP_TICK, 2'd0, 5'd0, 8'd0, '0);
    add_random_items(250, 400);
    drain();

    // Fastest timing: every sample and every unit lasts one tick, flat
    // amplitudes at the bottom, the middle and just under the middle.
    configure(15'd1, 8'h00, 15'd2, 8'h80, 15'd3, 8'h7F, 8'd1, 8'd1);
    add_random_items(250, 60);
    drain();

    // Zero hold and unit lengths, which act as one; a zero-length first
    // pulse and a full-scale amplitude.
    configure(15'd0, 8'hFF, 15'd5, 8'h01, 15'd1, 8'h55, 8'd0, 8'd0);
    add_random_items(250, 60);
    drain();

    // Random settings with short timing.
    repeat (3) begin
      configure(15'($urandom_range(0, 6)), 8'($urandom), 15'($urandom_range(0, 6)),
                8'($urandom), 15'($urandom_range(0, 6)), 8'($urandom),
                8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)));
      add_random_items(250, 100);
      drain();
    end

    configure(15'd7, 8'hC3, 15'd2, 8'h3C, 15'd4, 8'hE1, 8'd2, 8'd4);
    add_random_items(250, 120);
    drain();

    // Largest values everywhere. These sequences outlast the rest of the
    // run, so every load and start that follows the start is refused.
    configure(15'h7FFF, 8'hFF, 15'h7FFF, 8'hFF, 15'h7FFF, 8'hFF, 8'hFF, 8'hFF);
    add_item(OP_START, 2'd0, 5'd0, 8'd0, 18'(SEG_FLAT_THREE));
    add_random_items(150, 300);
    drain();

    if (predicted_results.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, predicted_results.size());
      errors++;
    end

    $display("Ran %0d transactions under %0d register settings.", accepted_count,
             settings_count);
    $display("%0d sequences came to an end and %0d loads or starts were refused.", done_seen,
             refused_seen);
    if (errors == 0) begin
      $display("dac_waveform_sequencer: match");
    end else begin
      $display("dac_waveform_sequencer: mismatch");
    end
    $finish;
  end

endmodule
